### rtl/two_level_bitmap_slot_allocator_unit_assert.svh
// assertion macros for the two-level bitmap slot allocator
// no dependencies; included by the allocator module, which carries the assertions
`ifndef TWO_LEVEL_BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_LEVEL_BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// clocked check, switched off while reset is asserted
`define TBSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TBSA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tbsa_pkg.sv
// shared types, codes and helpers of the two-level bitmap slot allocator
// no dependencies
package tbsa_pkg;

  localparam int unsigned MAP_WORDS_DEF = 4;
  localparam int unsigned CPW_DEF       = 64;
  localparam int unsigned CHUNK_W       = 8;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned SLOT_BITS     = 64;
  localparam int unsigned NUM_ENTRIES   = 256;

  // request codes
  typedef enum logic [1:0] {
    FUNC_ALLOC     = 2'd0,
    FUNC_FREE      = 2'd1,
    FUNC_NEW_CHUNK = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_CHUNK = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_CLAIM,
    ST_LINK_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [CHUNK_W-1:0]  chunk;
    logic [SLOT_W-1:0]   slot;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [CHUNK_W-1:0] chunk;
  } link_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } find_t;

  // lowest set bit of a 64-bit word
  function automatic find_t find_first_set(input logic [SLOT_BITS-1:0] vec);
    find_t r;
    r = '0;
    for (int i = SLOT_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r.found = 1'b1;
        r.idx   = SLOT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### rtl/two_level_bitmap_slot_allocator_unit.sv
// two-level bitmap slot allocator: chunk map in flops, slot maps and links in memories
// depends on tbsa_pkg and two_level_bitmap_slot_allocator_unit_assert.svh
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: func, chunk_id, slot.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   request: status, got_chunk, got_slot, in request order.
//   One request is worked on at a time; in_stall_o is low only while the
//   sequencer is idle. A finished result sits in the output register, so the
//   next request is taken while the receiver still stalls that result.
//   Steps from acceptance to out_valid_o, output register free:
//     unused code, reserved-slot free, out-of-range alloc or free: result stage only
//     free: read, modify, write of the slot map
//     new chunk: a scan of the chunk map, word by word
//     alloc: read and check of the start chunk, repeated for each link followed,
//     and, when a chunk is claimed, the map scan and a link write before it is read
//   The sequencer takes no new request until its result is loaded into the
//   output register. Throughput is limited by the registered read of the
//   slot-map and link memories and by the word-by-word scan.
//   Reset clears the chunk map and the control state; the memories are not
//   cleared, and no request may touch a chunk that was never claimed.
module two_level_bitmap_slot_allocator_unit
  import tbsa_pkg::*;
#(
  parameter int unsigned MAP_WORDS       = MAP_WORDS_DEF,
  parameter int unsigned CHUNKS_PER_WORD = CPW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_func_i,
  input  logic [CHUNK_W-1:0] in_chunk_id_i,
  input  logic [SLOT_W-1:0]  in_slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_status_o,
  output logic [CHUNK_W-1:0] out_got_chunk_o,
  output logic [SLOT_W-1:0]  out_got_slot_o
);

`include "two_level_bitmap_slot_allocator_unit_assert.svh"

  localparam int unsigned TOTAL     = MAP_WORDS * CHUNKS_PER_WORD;
  localparam int unsigned USABLE    = (TOTAL < NUM_ENTRIES) ? TOTAL : NUM_ENTRIES;
  localparam int unsigned LIMIT     = 2 * USABLE + 2;
  localparam int unsigned ITER_W    = $clog2(LIMIT + 1);
  localparam int unsigned WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = (CHUNKS_PER_WORD > 1) ? $clog2(CHUNKS_PER_WORD) : 1;
  localparam int unsigned LAST_W    = (USABLE - 1) / CHUNKS_PER_WORD;
  localparam int unsigned LAST_BITS = USABLE - LAST_W * CHUNKS_PER_WORD;
  localparam int unsigned NUM_W     = 14;

  state_e               state_q, state_d;
  func_e                op_q, op_d;
  logic [CHUNK_W-1:0]   cur_q, cur_d;
  logic [CHUNK_W-1:0]   new_q, new_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [ITER_W-1:0]    iter_q, iter_d;
  logic [WORD_W-1:0]    w_q, w_d;
  result_t              res_q, res_d;
  result_t              out_res_q;
  logic                 out_valid_q;
  logic                 out_load;

  logic [CHUNKS_PER_WORD-1:0] cmap_q [MAP_WORDS];
  logic                       cmap_set;

  logic [SLOT_BITS-1:0] slot_mem [NUM_ENTRIES];
  link_t                link_mem [NUM_ENTRIES];
  logic [SLOT_BITS-1:0] slot_rd_q;
  link_t                link_rd_q;
  logic                 mem_re;
  logic                 slot_we;
  logic [CHUNK_W-1:0]   slot_wa;
  logic [SLOT_BITS-1:0] slot_wd;
  logic                 link_we;
  logic [CHUNK_W-1:0]   link_wa;
  link_t                link_wd;

  logic [CHUNKS_PER_WORD-1:0] word_free;
  int unsigned                word_bits;
  find_t                      chunk_find;
  find_t                      slot_find;
  logic [NUM_W-1:0]           claim_full;
  logic [CHUNK_W-1:0]         claim_num;
  logic                       in_accept;
  logic                       in_oor;
  logic                       last_iter;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_oor = ({1'b0, in_chunk_id_i} >= (CHUNK_W + 1)'(USABLE));
  assign last_iter = (iter_q == ITER_W'(LIMIT - 1));

  // free chunks of the map word under scan
  always_comb begin
    word_bits = (w_q == WORD_W'(LAST_W)) ? LAST_BITS : CHUNKS_PER_WORD;
    for (int b = 0; b < CHUNKS_PER_WORD; b++) begin
      word_free[b] = !cmap_q[w_q][b] && (b < word_bits);
    end
  end

  assign chunk_find = find_first_set(SLOT_BITS'(word_free));
  assign claim_full = NUM_W'(w_q) * NUM_W'(CHUNKS_PER_WORD) + NUM_W'(chunk_find.idx);
  assign claim_num  = claim_full[CHUNK_W-1:0];

  // lowest free slot of the chunk just read
  assign slot_find = find_first_set(~slot_rd_q);

  // slot map memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (mem_re) begin
      slot_rd_q <= slot_mem[cur_q];
    end
  end

  // link memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (mem_re) begin
      link_rd_q <= link_mem[cur_q];
    end
  end

  // chunk-use map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmap_q <= '{default: '0};
    end else if (cmap_set) begin
      cmap_q[w_q][chunk_find.idx[BIT_W-1:0]] <= 1'b1;
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      w_q     <= w_d;
    end
  end

  // request context and result under construction
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cur_q  <= cur_d;
    new_q  <= new_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  // next state, memory control and result
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cur_d    = cur_q;
    new_d    = new_q;
    slot_d   = slot_q;
    iter_d   = iter_q;
    w_d      = w_q;
    res_d    = res_q;
    mem_re   = 1'b0;
    slot_we  = 1'b0;
    slot_wa  = cur_q;
    slot_wd  = slot_rd_q;
    link_we  = 1'b0;
    link_wa  = cur_q;
    link_wd  = '0;
    cmap_set = 1'b0;
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d   = func_e'(in_func_i);
          cur_d  = in_chunk_id_i;
          slot_d = in_slot_i;
          iter_d = '0;
          w_d    = '0;
          res_d  = '0;
          case (func_e'(in_func_i))
            FUNC_ALLOC: begin
              if (in_oor) begin
                res_d.status = STATUS_NO_CHUNK;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_ALLOC_RD;
              end
            end
            FUNC_FREE: begin
              if (in_oor) begin
                state_d = ST_RESP;
              end else if (in_slot_i == '0) begin
                res_d.status = STATUS_BAD_FREE;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_FREE_RD;
              end
            end
            FUNC_NEW_CHUNK: begin
              state_d = ST_CLAIM;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_FREE_RD: begin
        mem_re  = 1'b1;
        state_d = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        slot_we = 1'b1;
        slot_wd = slot_rd_q & ~(SLOT_BITS'(1) << slot_q);
        state_d = ST_RESP;
      end

      ST_ALLOC_RD: begin
        mem_re  = 1'b1;
        state_d = ST_ALLOC_CHK;
      end

      ST_ALLOC_CHK: begin
        if (slot_find.found) begin
          slot_we     = 1'b1;
          slot_wd     = slot_rd_q | (SLOT_BITS'(1) << slot_find.idx);
          res_d.chunk = cur_q;
          res_d.slot  = slot_find.idx;
          state_d     = ST_RESP;
        end else if (link_rd_q.valid) begin
          if ({1'b0, link_rd_q.chunk} >= (CHUNK_W + 1)'(USABLE) || last_iter) begin
            res_d.status = STATUS_NO_CHUNK;
            state_d      = ST_RESP;
          end else begin
            cur_d   = link_rd_q.chunk;
            iter_d  = iter_q + 1'b1;
            state_d = ST_ALLOC_RD;
          end
        end else begin
          w_d     = '0;
          state_d = ST_CLAIM;
        end
      end

      ST_CLAIM: begin
        if (chunk_find.found) begin
          cmap_set = 1'b1;
          slot_we  = 1'b1;
          slot_wa  = claim_num;
          slot_wd  = SLOT_BITS'(1);
          link_we  = 1'b1;
          link_wa  = claim_num;
          link_wd  = '0;
          if (op_q == FUNC_ALLOC) begin
            new_d   = claim_num;
            state_d = ST_LINK_WR;
          end else begin
            res_d.chunk = claim_num;
            state_d     = ST_RESP;
          end
        end else if (w_q == WORD_W'(LAST_W)) begin
          res_d.status = STATUS_NO_CHUNK;
          state_d      = ST_RESP;
        end else begin
          w_d = w_q + 1'b1;
        end
      end

      ST_LINK_WR: begin
        link_we       = 1'b1;
        link_wa       = cur_q;
        link_wd.valid = 1'b1;
        link_wd.chunk = new_q;
        if (last_iter) begin
          res_d.status = STATUS_NO_CHUNK;
          state_d      = ST_RESP;
        end else begin
          cur_d   = new_q;
          iter_d  = iter_q + 1'b1;
          state_d = ST_ALLOC_RD;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_res_q.status;
  assign out_got_chunk_o = out_res_q.chunk;
  assign out_got_slot_o  = out_res_q.slot;

  // checks
  `TBSA_ASSERT(a_err_no_payload, clk_i, rst_ni, (out_valid_q && out_res_q.status != STATUS_OK) |-> (out_res_q.chunk == '0 && out_res_q.slot == '0), "error result carries a chunk or slot")
  `TBSA_ASSERT(a_accept_busy, clk_i, rst_ni, in_accept |=> (state_q != ST_IDLE), "sequencer idle after accepting a transaction")
  `TBSA_ASSERT(a_iter_bound, clk_i, rst_ni, iter_q <= ITER_W'(LIMIT - 1), "chain walk passed its hop limit")
  `TBSA_ASSERT(a_word_bound, clk_i, rst_ni, w_q <= WORD_W'(LAST_W), "chunk scan passed the last usable word")
  `TBSA_ASSERT(a_resp_held, clk_i, rst_ni, (state_q == ST_RESP && out_valid_q && out_stall_i) |=> (state_q == ST_RESP), "result dropped while output stalled")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench for two_level_bitmap_slot_allocator_unit: queued request driver, result monitor
// and an in-order allocation predictor; depends on tbsa_pkg and the allocator rtl
module testbench;
  import tbsa_pkg::*;

  localparam int USABLE = (MAP_WORDS_DEF * CPW_DEF < NUM_ENTRIES) ?
                          MAP_WORDS_DEF * CPW_DEF : NUM_ENTRIES;
  localparam int HANG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    func_e              fn;
    logic [CHUNK_W-1:0] cid;
    logic [SLOT_W-1:0]  sl;
  } alloc_req_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         in_func_i = '0;
  logic [CHUNK_W-1:0] in_chunk_id_i = '0;
  logic [SLOT_W-1:0]  in_slot_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         out_status_o;
  logic [CHUNK_W-1:0] out_got_chunk_o;
  logic [SLOT_W-1:0]  out_got_slot_o;

  // stimulus and expected results
  alloc_req_t req_pending[$];
  result_t    alloc_due_q[$];
  alloc_req_t drive_req;
  result_t    due;

  // predictor copy of the allocator state
  bit [NUM_ENTRIES-1:0] chunk_used;
  bit [SLOT_BITS-1:0]   slot_bits[NUM_ENTRIES];
  bit [CHUNK_W-1:0]     link_to[NUM_ENTRIES];
  bit                   link_ok[NUM_ENTRIES];

  int  err_cnt = 0;
  int  taken_cnt = 0;
  int  result_cnt = 0;
  int  hang_cycles = 0;
  int  total_reqs = 0;
  int  cyc = 0;
  int  known_claimed = 0;
  int  new_issued = 0;
  bit  req_taken = 1'b0;
  logic calm;

  two_level_bitmap_slot_allocator_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_func_i       (in_func_i),
    .in_chunk_id_i   (in_chunk_id_i),
    .in_slot_i       (in_slot_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_status_o    (out_status_o),
    .out_got_chunk_o (out_got_chunk_o),
    .out_got_slot_o  (out_got_slot_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // claim the lowest unused chunk, -1 when none is left
  function automatic int claim_free_chunk();
    for (int n = 0; n < USABLE; n++) begin
      if (!chunk_used[n]) begin
        chunk_used[n] = 1'b1;
        slot_bits[n]  = 64'd1;
        link_to[n]    = '0;
        link_ok[n]    = 1'b0;
        return n;
      end
    end
    return -1;
  endfunction

  function automatic int lowest_clear(input bit [SLOT_BITS-1:0] map);
    for (int b = 0; b < SLOT_BITS; b++) begin
      if (!map[b]) return b;
    end
    return -1;
  endfunction

  // apply one request to the predictor state and return its result
  function automatic result_t predict_request(input logic [1:0] fn,
                                              input logic [CHUNK_W-1:0] cid,
                                              input logic [SLOT_W-1:0] sl);
    result_t r;
    int      cur;
    int      nxt;
    int      b;
    bit      done;
    r.status = STATUS_OK;
    r.chunk  = '0;
    r.slot   = '0;
    case (fn)
      FUNC_ALLOC: begin
        r.status = STATUS_NO_CHUNK;
        cur      = cid;
        done     = (cur >= USABLE);
        // walk the chain, extending it when the last chunk is full
        for (int hop = 0; hop < 2 * USABLE + 2 && !done; hop++) begin
          b = lowest_clear(slot_bits[cur]);
          if (b >= 0) begin
            slot_bits[cur][b] = 1'b1;
            r.status = STATUS_OK;
            r.chunk  = CHUNK_W'(cur);
            r.slot   = SLOT_W'(b);
            done     = 1'b1;
          end else begin
            if (link_ok[cur]) begin
              nxt = link_to[cur];
            end else begin
              nxt = claim_free_chunk();
              if (nxt >= 0) begin
                link_to[cur] = CHUNK_W'(nxt);
                link_ok[cur] = 1'b1;
              end
            end
            if (nxt < 0 || nxt >= USABLE) done = 1'b1;
            else cur = nxt;
          end
        end
      end
      FUNC_FREE: begin
        if (cid < USABLE) begin
          if (sl == '0) r.status = STATUS_BAD_FREE;
          else slot_bits[cid][sl] = 1'b0;
        end
      end
      FUNC_NEW_CHUNK: begin
        nxt = claim_free_chunk();
        if (nxt < 0) r.status = STATUS_NO_CHUNK;
        else r.chunk = CHUNK_W'(nxt);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s mismatch, got %0d expected %0d", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // queue one request; track a floor on the claimed chunks so only those are touched
  task automatic add_request(input func_e fn, input int cid, input int sl);
    alloc_req_t q;
    q.fn  = fn;
    q.cid = CHUNK_W'(cid);
    q.sl  = SLOT_W'(sl);
    req_pending.push_back(q);
    if (fn == FUNC_NEW_CHUNK) begin
      new_issued++;
      if (known_claimed < USABLE) known_claimed++;
    end
  endtask

  assign calm = (cyc >= 1500 && cyc < 3000);

  // driver: new transaction at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (!in_valid_i || req_taken) begin
        if (req_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          drive_req = req_pending.pop_front();
          in_valid_i    <= 1'b1;
          in_func_i     <= drive_req.fn;
          in_chunk_id_i <= drive_req.cid;
          in_slot_i     <= drive_req.sl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  // monitor: predict on each request transaction, check each result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_used  = '0;
      req_taken   <= 1'b0;
      hang_cycles <= 0;
    end else begin
      req_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        alloc_due_q.push_back(predict_request(in_func_i, in_chunk_id_i, in_slot_i));
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (alloc_due_q.size() == 0) begin
          report_mismatch("unexpected result, status", out_status_o, 0);
        end else begin
          due = alloc_due_q.pop_front();
          if (out_status_o !== due.status)
            report_mismatch("status", out_status_o, due.status);
          if (out_got_chunk_o !== due.chunk)
            report_mismatch("got_chunk", out_got_chunk_o, due.chunk);
          if (out_got_slot_o !== due.slot)
            report_mismatch("got_slot", out_got_slot_o, due.slot);
        end
        result_cnt <= result_cnt + 1;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        hang_cycles <= 0;
      else
        hang_cycles <= hang_cycles + 1;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    wait (hang_cycles >= HANG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    int cid;

    // directed: first claims, reserved-slot frees, reuse of a freed slot, unused code
    add_request(FUNC_NEW_CHUNK, 255, 63);
    add_request(FUNC_NEW_CHUNK, 0, 0);
    add_request(FUNC_ALLOC, 0, 63);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_ALLOC, 1, 21);
    add_request(FUNC_FREE, 0, 0);
    add_request(FUNC_FREE, 0, 1);
    add_request(FUNC_ALLOC, 0, 42);
    add_request(FUNC_FREE, 0, 63);
    add_request(FUNC_FREE, 1, 0);
    add_request(FUNC_NONE, 1, 63);
    add_request(FUNC_NONE, 0, 0);
    add_request(FUNC_FREE, 0, 2);
    add_request(FUNC_FREE, 0, 1);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_ALLOC, 0, 63);
    add_request(FUNC_FREE, 1, 1);
    add_request(FUNC_NEW_CHUNK, 128, 32);

    // mixed traffic, allocs mostly on the first chunks so their chains grow
    for (int i = 0; i < 600; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        cid = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 1) :
              $urandom_range(0, known_claimed - 1);
        add_request(FUNC_ALLOC, cid, $urandom_range(0, 63));
      end else if (r < 75) begin
        cid = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 1) :
              $urandom_range(0, known_claimed - 1);
        add_request(FUNC_FREE, cid, ($urandom_range(0, 1) != 0) ?
                    $urandom_range(0, 15) : $urandom_range(0, 63));
      end else if (r < 95) begin
        add_request(FUNC_NEW_CHUNK, $urandom_range(0, 255), $urandom_range(0, 63));
      end else begin
        add_request(FUNC_NONE, $urandom_range(0, known_claimed - 1), $urandom_range(0, 63));
      end
    end

    // claim every chunk, then run out of chunks a few times
    while (new_issued < USABLE + 6) begin
      if ($urandom_range(0, 99) < 80)
        add_request(FUNC_NEW_CHUNK, $urandom_range(0, 255), $urandom_range(0, 63));
      else
        add_request(FUNC_ALLOC, $urandom_range(0, known_claimed - 1), $urandom_range(0, 63));
    end

    // fill the last chunks with no free chunk left, freeing slots now and then
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        add_request(FUNC_ALLOC, $urandom_range(USABLE - 2, USABLE - 1), $urandom_range(0, 63));
      else if (r < 90)
        add_request(FUNC_FREE, $urandom_range(USABLE - 2, USABLE - 1), $urandom_range(0, 63));
      else if (r < 95)
        add_request(FUNC_NEW_CHUNK, $urandom_range(0, 255), $urandom_range(0, 63));
      else
        add_request(FUNC_NONE, $urandom_range(0, USABLE - 1), $urandom_range(0, 63));
    end
    total_reqs = req_pending.size();

    // reset
    repeat (7) @(posedge clk_i);
    #3 rst_ni = 1'b1;

    // wait for every result, then a quiet tail
    wait (taken_cnt == total_reqs && alloc_due_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
